// File: sv/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared widths, opcodes and controller/datapath interface structs for the
// pancake flip successor block.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int CNT_W  = 5;
  localparam int SLOT_W = 4;
  localparam int ID_W   = 8;
  localparam int COST_W = 16;
  localparam int GAP_W  = 4;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_EXPAND = 1'b1;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam logic [GAP_W-1:0]  GAP_MAX  = {GAP_W{1'b1}};

  typedef struct packed {
    logic load;       // write one id into the stack
    logic expand;     // latch flip, cost and count, restart position
    logic issue;      // read the stack at the current position
    logic scan;       // issued read feeds the gap count, not the output
    logic clear_pos;  // rewind the position counter
  } pfs_cmd_t;

  typedef struct packed {
    logic skip;       // expand repeats the previous flip
    logic last_pos;   // position counter sits on the last element
  } pfs_sts_t;

endpackage

// File: sv/pancake_flip_successor.sv
// a load writes one stack slot; an expand with n pancakes in use stays busy
// through a gap scan pass and an emit pass (n positions each, one stack read each)
// and its elements follow the registered emit pass reads, one per cycle
// an expand that repeats the previous flip is dropped, no beats
// reset: synchronous active low, idle, pancake count 16, stack left unwritten
// the receiver cannot stall: each out_valid beat is taken in its cycle
// ----------------------------------------------------------------------------
// pancake_flip_successor
// Expands one pancake-sorting node: flips the top of the stored stack and
// emits the successor with its gap count, new cost and estimate.
// ----------------------------------------------------------------------------
module pancake_flip_successor import pfs_pkg::*; #(
  parameter int MAX_PANCAKES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [SLOT_W-1:0] in_slot_index,
  input  logic [ID_W-1:0]   in_pancake_id,
  input  logic [CNT_W-1:0]  in_flip_size,
  input  logic [COST_W-1:0] in_path_cost,
  input  logic [CNT_W-1:0]  in_previous_flip,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_slot,
  output logic [ID_W-1:0]   out_id,
  output logic              out_last_element,
  output logic [GAP_W-1:0]  out_gap_count,
  output logic [COST_W-1:0] out_new_cost,
  output logic [COST_W-1:0] out_estimate,
  output logic [CNT_W-1:0]  out_applied_flip
);

  pfs_cmd_t cmd;
  pfs_sts_t sts;

  pfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  pfs_datapath #(
    .MAX_PANCAKES (MAX_PANCAKES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_slot_index    (in_slot_index),
    .in_pancake_id    (in_pancake_id),
    .in_flip_size     (in_flip_size),
    .in_path_cost     (in_path_cost),
    .in_previous_flip (in_previous_flip),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_slot         (out_slot),
    .out_id           (out_id),
    .out_last_element (out_last_element),
    .out_gap_count    (out_gap_count),
    .out_new_cost     (out_new_cost),
    .out_estimate     (out_estimate),
    .out_applied_flip (out_applied_flip)
  );

endmodule

// File: sv/pfs_ctrl.sv
// ----------------------------------------------------------------------------
// pfs_ctrl
// Sequencer: gap scan pass over the successor, then an emit pass that
// sends one element per cycle.
// ----------------------------------------------------------------------------
module pfs_ctrl import pfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_opcode,
  input  pfs_sts_t sts,
  output pfs_cmd_t cmd,
  output logic     busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_opcode == OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (!sts.skip) begin
            cmd.expand = 1'b1;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        cmd.scan  = 1'b1;
        if (sts.last_pos) begin
          cmd.clear_pos = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.issue = 1'b1;
        if (sts.last_pos) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: sv/pfs_datapath.sv
// ----------------------------------------------------------------------------
// pfs_datapath
// Stack memory, flipped address generation, gap counter, cost and estimate.
// ----------------------------------------------------------------------------
module pfs_datapath import pfs_pkg::*; #(
  parameter int MAX_PANCAKES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic [SLOT_W-1:0] in_slot_index,
  input  logic [ID_W-1:0]   in_pancake_id,
  input  logic [CNT_W-1:0]  in_flip_size,
  input  logic [COST_W-1:0] in_path_cost,
  input  logic [CNT_W-1:0]  in_previous_flip,
  input  pfs_cmd_t          cmd,
  output pfs_sts_t          sts,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_slot,
  output logic [ID_W-1:0]   out_id,
  output logic              out_last_element,
  output logic [GAP_W-1:0]  out_gap_count,
  output logic [COST_W-1:0] out_new_cost,
  output logic [COST_W-1:0] out_estimate,
  output logic [CNT_W-1:0]  out_applied_flip
);

  localparam int IW = (MAX_PANCAKES > 1) ? $clog2(MAX_PANCAKES) : 1;
  localparam int CW = $clog2(MAX_PANCAKES + 1);
  localparam int AW = (CW > CNT_W) ? CW : CNT_W;

  logic [ID_W-1:0]   mem [MAX_PANCAKES];

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  k_r;
  logic [CNT_W-1:0]  pos_r;
  logic [CNT_W-1:0]  rd_pos_r;
  logic              rd_scan_r;
  logic              rd_emit_r;
  logic [ID_W-1:0]   rd_data_r;
  logic [ID_W-1:0]   prev_r;
  logic [GAP_W-1:0]  gap_r;
  logic [COST_W-1:0] ncost_r;

  logic [CNT_W-1:0]  n_nxt;
  logic [CNT_W-1:0]  k_nxt;
  logic [AW-1:0]     cnt_ext;
  logic [AW-1:0]     slot_ext;
  logic [CNT_W-1:0]  addr;
  logic [AW-1:0]     addr_ext;
  logic              is_gap;
  logic [COST_W:0]   est_sum;

  // clamp the count register to 2..MAX_PANCAKES, then the flip to the count
  always_comb begin
    cnt_ext = AW'(count_r);
    if (cnt_ext < AW'(2)) begin
      n_nxt = CNT_W'(2);
    end else if (cnt_ext > AW'(MAX_PANCAKES)) begin
      n_nxt = CNT_W'(MAX_PANCAKES);
    end else begin
      n_nxt = count_r;
    end
    k_nxt = (in_flip_size > n_nxt) ? n_nxt : in_flip_size;
  end

  assign sts.skip     = (in_flip_size == in_previous_flip);
  assign sts.last_pos = (pos_r == n_r - CNT_W'(1));

  // positions under the flip read the stack mirrored
  assign addr     = (pos_r < k_r) ? (k_r - CNT_W'(1) - pos_r) : pos_r;
  assign addr_ext = AW'(addr);
  assign slot_ext = AW'(in_slot_index);

  always_ff @(posedge clk) begin
    if (cmd.load && (slot_ext < AW'(MAX_PANCAKES))) begin
      mem[slot_ext[IW-1:0]] <= in_pancake_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[addr_ext[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= CNT_W'(16);
      pos_r     <= '0;
      rd_scan_r <= 1'b0;
      rd_emit_r <= 1'b0;
      gap_r     <= '0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (cmd.expand || cmd.clear_pos) begin
        pos_r <= '0;
      end else if (cmd.issue) begin
        pos_r <= pos_r + CNT_W'(1);
      end
      rd_scan_r <= cmd.issue && cmd.scan;
      rd_emit_r <= cmd.issue && !cmd.scan;
      if (cmd.expand) begin
        gap_r <= '0;
      end else if (rd_scan_r && (rd_pos_r != '0) && is_gap && (gap_r != GAP_MAX)) begin
        gap_r <= gap_r + GAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.expand) begin
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      ncost_r <= (in_path_cost == COST_MAX) ? COST_MAX : in_path_cost + COST_W'(1);
    end
    if (cmd.issue) begin
      rd_pos_r <= pos_r;
    end
    if (rd_scan_r) begin
      prev_r <= rd_data_r;
    end
  end

  // neighbors differing by exactly one are no gap
  assign is_gap = ({1'b0, prev_r} + 9'd1 != {1'b0, rd_data_r}) &&
                  ({1'b0, rd_data_r} + 9'd1 != {1'b0, prev_r});

  assign est_sum = {1'b0, ncost_r} + (COST_W + 1)'(gap_r);

  assign out_valid        = rd_emit_r;
  assign out_slot         = rd_pos_r[SLOT_W-1:0];
  assign out_id           = rd_data_r;
  assign out_last_element = (rd_pos_r == n_r - CNT_W'(1));
  assign out_gap_count    = gap_r;
  assign out_new_cost     = ncost_r;
  assign out_estimate     = est_sum[COST_W] ? COST_MAX : est_sum[COST_W-1:0];
  assign out_applied_flip = k_r;

endmodule

// File: sim/pfs_successor_check.sv
// ----------------------------------------------------------------------------
// pfs_successor_check
// Watches the command, result and count-register ports of the pancake flip
// successor block. Keeps its own stack and count, predicts every successor
// element of an accepted expand and compares each result beat with it.
// ----------------------------------------------------------------------------
module pfs_successor_check import pfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              start,
  input  logic              busy,
  input  logic              in_opcode,
  input  logic [SLOT_W-1:0] in_slot_index,
  input  logic [ID_W-1:0]   in_pancake_id,
  input  logic [CNT_W-1:0]  in_flip_size,
  input  logic [COST_W-1:0] in_path_cost,
  input  logic [CNT_W-1:0]  in_previous_flip,
  input  logic              out_valid,
  input  logic [SLOT_W-1:0] out_slot,
  input  logic [ID_W-1:0]   out_id,
  input  logic              out_last_element,
  input  logic [GAP_W-1:0]  out_gap_count,
  input  logic [COST_W-1:0] out_new_cost,
  input  logic [COST_W-1:0] out_estimate,
  input  logic [CNT_W-1:0]  out_applied_flip,
  output int                err_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 16;
  localparam int FW          = COST_W + 1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic              last;
    logic [GAP_W-1:0]  gaps;
    logic [COST_W-1:0] cost;
    logic [COST_W-1:0] est;
    logic [CNT_W-1:0]  flip;
  } succ_elem_t;

  succ_elem_t       succ_elems[$];
  logic [ID_W-1:0]  stack_copy[STACK_DEPTH];
  logic [CNT_W-1:0] count_reg;
  int               errors;
  succ_elem_t       head;

  // flip the top of the stored stack and queue one element per position
  function automatic void expand_successor(input logic [CNT_W-1:0] flip,
                                           input logic [COST_W-1:0] cost);
    int               n;
    int               k;
    int               gaps;
    int               a;
    int               b;
    logic [ID_W-1:0]  succ[STACK_DEPTH];
    logic [COST_W-1:0] ncost;
    logic [COST_W:0]  sum;
    succ_elem_t       e;
    n = (count_reg < 2) ? 2 : ((count_reg > STACK_DEPTH) ? STACK_DEPTH : int'(count_reg));
    k = (flip > n) ? n : int'(flip);
    for (int i = 0; i < STACK_DEPTH; i++) succ[i] = stack_copy[i];
    for (int i = 0; i < k; i++) succ[i] = stack_copy[k - 1 - i];
    gaps = 0;
    for (int i = 0; i + 1 < n; i++) begin
      a = succ[i];
      b = succ[i + 1];
      if (a + 1 != b && b + 1 != a) gaps++;
    end
    if (gaps > GAP_MAX) gaps = GAP_MAX;
    ncost = (cost == COST_MAX) ? COST_MAX : cost + 1'b1;
    sum   = {1'b0, ncost} + FW'(gaps);
    for (int i = 0; i < n; i++) begin
      e.slot = SLOT_W'(i);
      e.id   = succ[i];
      e.last = (i + 1 == n);
      e.gaps = GAP_W'(gaps);
      e.cost = ncost;
      e.est  = (sum > COST_MAX) ? COST_MAX : sum[COST_W-1:0];
      e.flip = CNT_W'(k);
      succ_elems.push_back(e);
    end
  endfunction

  task automatic check_field(input string name, input logic [COST_W:0] expv,
                             input logic [COST_W:0] actv);
    if (actv !== expv) begin
      if (errors < 50)
        $display("%0t: %s expected %0d got %0d", $time, name, expv, actv);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      succ_elems.delete();
      count_reg = 5'd16;
    end else begin
      if (out_valid) begin
        if (succ_elems.size() == 0) begin
          if (errors < 50)
            $display("%0t: beat expected none got slot %0d id %0d", $time, out_slot, out_id);
          errors++;
        end else begin
          head = succ_elems.pop_front();
          check_field("out_slot", FW'(head.slot), FW'(out_slot));
          check_field("out_id", FW'(head.id), FW'(out_id));
          check_field("out_last_element", FW'(head.last), FW'(out_last_element));
          check_field("out_gap_count", FW'(head.gaps), FW'(out_gap_count));
          check_field("out_new_cost", FW'(head.cost), FW'(out_new_cost));
          check_field("out_estimate", FW'(head.est), FW'(out_estimate));
          check_field("out_applied_flip", FW'(head.flip), FW'(out_applied_flip));
        end
      end
      if (cfg_we) count_reg = cfg_wdata;
      if (start && !busy) begin
        if (in_opcode == OP_LOAD)
          stack_copy[in_slot_index] = in_pancake_id;
        else if (in_flip_size != in_previous_flip)
          expand_successor(in_flip_size, in_path_cost);
      end
    end
    err_count <= errors;
    pending   <= succ_elems.size();
  end

endmodule

// File: sim/pancake_flip_successor_tb.sv
// ----------------------------------------------------------------------------
// pancake_flip_successor_tb
// Loads the stack, runs directed expands over the flip, cost and skip corners,
// then random load/expand traffic under several pancake counts with random
// sender gaps; the checker beside the block scores every result beat.
// ----------------------------------------------------------------------------
module pancake_flip_successor_tb import pfs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 14;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CNT_W-1:0]  cfg_wdata;
  logic              start;
  logic              busy;
  logic              in_opcode;
  logic [SLOT_W-1:0] in_slot_index;
  logic [ID_W-1:0]   in_pancake_id;
  logic [CNT_W-1:0]  in_flip_size;
  logic [COST_W-1:0] in_path_cost;
  logic [CNT_W-1:0]  in_previous_flip;
  logic              out_valid;
  logic [SLOT_W-1:0] out_slot;
  logic [ID_W-1:0]   out_id;
  logic              out_last_element;
  logic [GAP_W-1:0]  out_gap_count;
  logic [COST_W-1:0] out_new_cost;
  logic [COST_W-1:0] out_estimate;
  logic [CNT_W-1:0]  out_applied_flip;
  int                err_count;
  int                pending;

  int                cycles;
  logic              idle_on;
  logic [ID_W-1:0]   id_base;
  logic [CNT_W-1:0]  phase_counts[8];

  pancake_flip_successor i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_slot_index    (in_slot_index),
    .in_pancake_id    (in_pancake_id),
    .in_flip_size     (in_flip_size),
    .in_path_cost     (in_path_cost),
    .in_previous_flip (in_previous_flip),
    .out_valid        (out_valid),
    .out_slot         (out_slot),
    .out_id           (out_id),
    .out_last_element (out_last_element),
    .out_gap_count    (out_gap_count),
    .out_new_cost     (out_new_cost),
    .out_estimate     (out_estimate),
    .out_applied_flip (out_applied_flip)
  );

  pfs_successor_check i_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_slot_index    (in_slot_index),
    .in_pancake_id    (in_pancake_id),
    .in_flip_size     (in_flip_size),
    .in_path_cost     (in_path_cost),
    .in_previous_flip (in_previous_flip),
    .out_valid        (out_valid),
    .out_slot         (out_slot),
    .out_id           (out_id),
    .out_last_element (out_last_element),
    .out_gap_count    (out_gap_count),
    .out_new_cost     (out_new_cost),
    .out_estimate     (out_estimate),
    .out_applied_flip (out_applied_flip),
    .err_count        (err_count),
    .pending          (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // present one command and hold it until the beat is taken
  task automatic push_item(input logic op, input logic [SLOT_W-1:0] slot,
                           input logic [ID_W-1:0] id, input logic [CNT_W-1:0] flip,
                           input logic [COST_W-1:0] cost, input logic [CNT_W-1:0] prev);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start            <= 1'b1;
    in_opcode        <= op;
    in_slot_index    <= slot;
    in_pancake_id    <= id;
    in_flip_size     <= flip;
    in_path_cost     <= cost;
    in_previous_flip <= prev;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // count register only changes with the block idle
  task automatic write_count(input logic [CNT_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  flip;
    logic [CNT_W-1:0]  prev;
    logic [COST_W-1:0] cost;
    slot = SLOT_W'($urandom_range(0, 15));
    flip = CNT_W'($urandom);
    prev = CNT_W'($urandom);
    cost = COST_W'($urandom);
    if ($urandom_range(0, 99) < 35) begin
      // mostly runs of consecutive ids so the gap count spreads out
      if ($urandom_range(0, 3) == 0) id = ID_W'($urandom);
      else id = id_base + ID_W'(slot);
      push_item(OP_LOAD, slot, id, flip, cost, prev);
    end else begin
      id = ID_W'($urandom);
      if ($urandom_range(0, 3) != 0) flip = CNT_W'($urandom_range(0, 16));
      if ($urandom_range(0, 6) == 0) prev = flip;
      case ($urandom_range(0, 9))
        0: cost = COST_MAX;
        1: cost = COST_MAX - 1'b1;
        2: cost = '0;
        default: ;
      endcase
      push_item(OP_EXPAND, slot, id, flip, cost, prev);
    end
  endtask

  initial begin
    idle_on          = 1'b1;
    id_base          = '0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    start            = 1'b0;
    in_opcode        = OP_LOAD;
    in_slot_index    = '0;
    in_pancake_id    = '0;
    in_flip_size     = '0;
    in_path_cost     = '0;
    in_previous_flip = '0;
    phase_counts     = '{5'd2, 5'd0, 5'd31, 5'd1, 5'd9, 5'd17, 5'd16, 5'd5};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_count(5'd16);

    // fill every slot before any expand reads the stack; ids sorted
    for (int i = 0; i < 16; i++) push_item(OP_LOAD, SLOT_W'(i), ID_W'(i), '0, '0, '0);
    push_item(OP_EXPAND, '0, '0, 5'd0, 16'd0, 5'd1);
    push_item(OP_EXPAND, '0, '0, 5'd16, COST_MAX, 5'd0);
    push_item(OP_EXPAND, '0, '0, 5'd7, 16'd65534, 5'd16);   // estimate saturates
    push_item(OP_EXPAND, '0, '0, 5'd31, 16'd1234, 5'd30);   // flip clamps to count
    push_item(OP_EXPAND, '0, '0, 5'd1, 16'd5, 5'd1);        // repeated flip
    push_item(OP_EXPAND, '0, '0, 5'd1, 16'd7, 5'd0);
    push_item(OP_LOAD, 4'd15, 8'd255, 5'd31, COST_MAX, 5'd31);
    push_item(OP_LOAD, 4'd8, 8'd170, '0, '0, '0);
    push_item(OP_EXPAND, '0, '0, 5'd31, 16'd9, 5'd31);      // raw values equal
    push_item(OP_EXPAND, 4'd15, 8'd255, 5'd17, 16'hAAAA, 5'd16);

    foreach (phase_counts[p]) begin
      if (p == 7) write_count(CNT_W'($urandom_range(3, 15)));
      else write_count(phase_counts[p]);
      id_base = ID_W'($urandom_range(0, 239));
      idle_on = (p != 4);
      for (int j = 0; j < ITEMS_PER_PHASE; j++) random_item();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (err_count == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
sv/pfs_pkg.sv
sv/pfs_ctrl.sv
sv/pfs_datapath.sv
sv/pancake_flip_successor.sv
sim/pfs_successor_check.sv
sim/pancake_flip_successor_tb.sv
